// ----- hdl/staggered_grid_destagger_macros.svh -----
// Assertion macros shared by the destagger modules
`ifndef STAGGERED_GRID_DESTAGGER_MACROS_SVH
`define STAGGERED_GRID_DESTAGGER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SGD_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("staggered_grid_destagger: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SGD_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("staggered_grid_destagger: next-cycle check failed");

`endif

// ----- hdl/sgd_pkg.sv -----
// Shared types, register codes and the averaging function of the destagger
package sgd_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_X_SIZE       = 3'd0,
    REG_Y_SIZE       = 3'd1,
    REG_Z_SIZE       = 3'd2,
    REG_X_STAGGERED  = 3'd3,
    REG_Y_STAGGERED  = 3'd4,
    REG_Z_STAGGERED  = 3'd5,
    REG_MISSING_EN   = 3'd6,
    REG_MISSING_CODE = 3'd7
  } reg_idx_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  // What one pass does with a transaction
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FILL = 2'd1,
    OP_AVG  = 2'd2
  } pass_op_t;

  typedef struct packed {
    logic [8:0]          x_size;
    logic [8:0]          y_size;
    logic [12:0]         z_size;
    logic                x_staggered;
    logic                y_staggered;
    logic                z_staggered;
    logic                missing_en;
    logic signed [31:0]  missing_code;
  } cfg_t;

  // Control carried with each queued transaction from front to back
  typedef struct packed {
    pass_op_t y_op;
    pass_op_t z_op;
    logic     row_end;
    logic     slice_end;
    logic     volume_end;
  } ctl_t;

  // floor((a+b)/2) in signed Q16.16, or the missing code when either side is missing
  function automatic logic signed [31:0] avg2(
    input logic signed [31:0] a,
    input logic signed [31:0] b,
    input logic               miss_en,
    input logic signed [31:0] miss_code
  );
    logic signed [32:0] sum;
    logic signed [31:0] res;
    sum = {a[31], a} + {b[31], b};
    if (miss_en && ((a == miss_code) || (b == miss_code))) begin
      res = miss_code;
    end else begin
      res = sum[32:1];
    end
    return res;
  endfunction

endpackage

// ----- hdl/staggered_grid_destagger.sv -----
// Top level of the staggered grid destagger: configuration registers, front, queue, back
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_sample
//  out_     output     out_valid / out_stall  out_value, out_row_end, out_slice_end,
//                                             out_volume_end
//  cfg_     input      cfg_wr_en              cfg_index, cfg_wdata
//
// One sample is taken per cycle while in_stall is low; a result passes through the queue,
// the row store read, the slice store read and the output register, in that order.
// Samples that only prime a stage give no result.
// Reset (rst_n low, synchronous) loads the register defaults, zeroes the raster
// position and empties the queue and pipeline; the stores need no clearing.
// out_stall freezes the back end; the four-entry queue keeps taking samples until full.
module staggered_grid_destagger #(
  parameter int unsigned MAX_X = 256,
  parameter int unsigned MAX_Y = 256,
  parameter int unsigned MAX_Z = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [31:0]                   in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_value,
  output logic                                 out_row_end,
  output logic                                 out_slice_end,
  output logic                                 out_volume_end,
  input  logic                                 cfg_wr_en,
  input  logic [sgd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sgd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import sgd_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_X);
  localparam int unsigned SW    = $clog2(MAX_X * MAX_Y);
  localparam int unsigned CTL_W = $bits(ctl_t);
  localparam int unsigned QW    = CTL_W + SAMPLE_W + XW + SW;

  cfg_t               cfg_r, cfg_nxt;
  logic               f_push;
  ctl_t               f_ctl;
  logic signed [31:0] f_value;
  logic [XW-1:0]      f_row_addr;
  logic [SW-1:0]      f_slice_addr;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  ctl_t               h_ctl;
  logic signed [31:0] h_value;
  logic [XW-1:0]      h_row_addr;
  logic [SW-1:0]      h_slice_addr;

  // Decode a configuration write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_X_SIZE:       cfg_nxt.x_size       = cfg_wdata[8:0];
        REG_Y_SIZE:       cfg_nxt.y_size       = cfg_wdata[8:0];
        REG_Z_SIZE:       cfg_nxt.z_size       = cfg_wdata[12:0];
        REG_X_STAGGERED:  cfg_nxt.x_staggered  = cfg_wdata[0];
        REG_Y_STAGGERED:  cfg_nxt.y_staggered  = cfg_wdata[0];
        REG_Z_STAGGERED:  cfg_nxt.z_staggered  = cfg_wdata[0];
        REG_MISSING_EN:   cfg_nxt.missing_en   = cfg_wdata[0];
        REG_MISSING_CODE: cfg_nxt.missing_code = signed'(cfg_wdata);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_size       <= 9'd256;
      cfg_r.y_size       <= 9'd256;
      cfg_r.z_size       <= 13'd1;
      cfg_r.x_staggered  <= 1'b0;
      cfg_r.y_staggered  <= 1'b0;
      cfg_r.z_staggered  <= 1'b0;
      cfg_r.missing_en   <= 1'b0;
      cfg_r.missing_code <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sgd_front #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .restart         (cfg_wr_en),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .q_full          (q_full),
    .push            (f_push),
    .push_ctl        (f_ctl),
    .push_value      (f_value),
    .push_row_addr   (f_row_addr),
    .push_slice_addr (f_slice_addr)
  );

  // Pack and unpack the queued transaction
  assign q_wdata      = {f_ctl, f_value, f_row_addr, f_slice_addr};
  assign h_ctl        = ctl_t'(q_rdata[QW-1 -: CTL_W]);
  assign h_value      = signed'(q_rdata[SAMPLE_W+XW+SW-1 -: SAMPLE_W]);
  assign h_row_addr   = q_rdata[XW+SW-1 -: XW];
  assign h_slice_addr = q_rdata[SW-1:0];

  sgd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  sgd_back #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (q_valid),
    .head_ctl        (h_ctl),
    .head_value      (h_value),
    .head_row_addr   (h_row_addr),
    .head_slice_addr (h_slice_addr),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_row_end     (out_row_end),
    .out_slice_end   (out_slice_end),
    .out_volume_end  (out_volume_end)
  );

endmodule

// ----- hdl/sgd_ram.sv -----
// Generic simple dual-port RAM with registered read
module sgd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read at a written address gives the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/sgd_front.sv -----
// Front end: raster position tracking, x pass and classification of each sample
module sgd_front #(
  parameter int unsigned MAX_X = 256,
  parameter int unsigned MAX_Y = 256,
  parameter int unsigned MAX_Z = 4096,
  localparam int unsigned XW = $clog2(MAX_X),
  localparam int unsigned YW = $clog2(MAX_Y),
  localparam int unsigned ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1,
  localparam int unsigned SW = $clog2(MAX_X * MAX_Y)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sgd_pkg::cfg_t       cfg,
  input  logic                restart,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_sample,
  input  logic                q_full,
  output logic                push,
  output sgd_pkg::ctl_t       push_ctl,
  output logic signed [31:0]  push_value,
  output logic [XW-1:0]       push_row_addr,
  output logic [SW-1:0]       push_slice_addr
);
  import sgd_pkg::*;

  // Last valid index of an axis after clamping the size into 1..max
  function automatic logic [31:0] last_of(input logic [31:0] size, input logic [31:0] maxv);
    logic [31:0] r;
    if (size == 32'd0) begin
      r = 32'd0;
    end else if (size > maxv) begin
      r = maxv - 32'd1;
    end else begin
      r = size - 32'd1;
    end
    return r;
  endfunction

  logic [XW-1:0]      x_r, x_nxt, x_last;
  logic [YW-1:0]      y_r, y_nxt, y_last;
  logic [ZW-1:0]      z_r, z_nxt, z_last;
  logic [SW-1:0]      p_r, p_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic               accept;
  logic               x_keep;
  logic               y_survive;
  logic               row_end, slice_end, volume_end;
  pass_op_t           y_op, z_op;

  assign x_last = XW'(last_of(32'(cfg.x_size), 32'(MAX_X)));
  assign y_last = YW'(last_of(32'(cfg.y_size), 32'(MAX_Y)));
  assign z_last = ZW'(last_of(32'(cfg.z_size), 32'(MAX_Z)));

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the sample against the staggered axes
  always_comb begin
    x_keep    = !cfg.x_staggered || (x_r != '0);
    y_survive = !cfg.y_staggered || (y_r != '0);
    if (!cfg.y_staggered) begin
      y_op = OP_NONE;
    end else if (y_r == '0) begin
      y_op = OP_FILL;
    end else begin
      y_op = OP_AVG;
    end
    if (!cfg.z_staggered || !y_survive) begin
      z_op = OP_NONE;
    end else if (z_r == '0) begin
      z_op = OP_FILL;
    end else begin
      z_op = OP_AVG;
    end
    row_end    = (x_r == x_last);
    slice_end  = row_end && (y_r == y_last);
    volume_end = slice_end && (z_r == z_last);
  end

  assign push                = accept && x_keep;
  assign push_ctl.y_op       = y_op;
  assign push_ctl.z_op       = z_op;
  assign push_ctl.row_end    = row_end;
  assign push_ctl.slice_end  = slice_end;
  assign push_ctl.volume_end = volume_end;
  assign push_value          = cfg.x_staggered ?
                               avg2(prev_r, in_sample, cfg.missing_en, cfg.missing_code) :
                               in_sample;
  assign push_row_addr       = cfg.x_staggered ? (x_r - XW'(1)) : x_r;
  assign push_slice_addr     = p_r;

  // Advance the raster position, the slice address and the previous sample
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    p_nxt    = p_r;
    prev_nxt = prev_r;
    if (restart) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
      p_nxt = '0;
    end else if (accept) begin
      if (cfg.x_staggered) begin
        prev_nxt = in_sample;
      end
      if (x_keep && (z_op != OP_NONE)) begin
        p_nxt = slice_end ? '0 : (p_r + SW'(1));
      end
      if (x_r == x_last) begin
        x_nxt = '0;
        if (y_r == y_last) begin
          y_nxt = '0;
          z_nxt = (z_r == z_last) ? '0 : (z_r + ZW'(1));
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      z_r    <= '0;
      p_r    <= '0;
      prev_r <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      p_r    <= p_nxt;
      prev_r <= prev_nxt;
    end
  end

`include "staggered_grid_destagger_macros.svh"

  // The first sample of a row on a staggered x axis only primes the x pass
  `SGD_ASSERT_NOW(a_x_start_dropped, clk, rst_n, accept && cfg.x_staggered && (x_r == '0), !push)
  // A pushed transaction never lands on a full queue
  `SGD_ASSERT_NOW(a_push_has_room, clk, rst_n, push, !q_full)

endmodule

// ----- hdl/sgd_queue.sv -----
// Short FIFO between the front end and the back end
module sgd_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // Step the pointers and the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : (wr_ptr_r + PW'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : (rd_ptr_r + PW'(1));
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`include "staggered_grid_destagger_macros.svh"

  `SGD_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, pop_valid)
  `SGD_ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop, count_r == $past(count_r) + CW'(1))

endmodule

// ----- hdl/sgd_back.sv -----
// Back end: y pass over the row store, z pass over the slice store, output register
module sgd_back #(
  parameter int unsigned MAX_X = 256,
  parameter int unsigned MAX_Y = 256,
  localparam int unsigned XW = $clog2(MAX_X),
  localparam int unsigned SW = $clog2(MAX_X * MAX_Y)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sgd_pkg::cfg_t       cfg,
  input  logic                head_valid,
  input  sgd_pkg::ctl_t       head_ctl,
  input  logic signed [31:0]  head_value,
  input  logic [XW-1:0]       head_row_addr,
  input  logic [SW-1:0]       head_slice_addr,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_value,
  output logic                out_row_end,
  output logic                out_slice_end,
  output logic                out_volume_end
);
  import sgd_pkg::*;

  logic               adv;

  // Stage 1: row store read data arrives
  logic               s1_valid_r;
  ctl_t               s1_ctl_r;
  logic signed [31:0] s1_value_r;
  logic [XW-1:0]      s1_row_addr_r;
  logic [SW-1:0]      s1_slice_addr_r;
  logic               s1_fwd_r;
  logic signed [31:0] s1_fwd_data_r;
  logic [31:0]        row_rd_data;
  logic signed [31:0] row_old;
  logic signed [31:0] y_value;
  logic               row_wr_en;

  // Stage 2: slice store read data arrives
  logic               s2_valid_r;
  ctl_t               s2_ctl_r;
  logic signed [31:0] s2_value_r;
  logic [SW-1:0]      s2_slice_addr_r;
  logic               s2_fwd_r;
  logic signed [31:0] s2_fwd_data_r;
  logic [31:0]        slice_rd_data;
  logic signed [31:0] slice_old;
  logic signed [31:0] z_value;
  logic               slice_rd_en;
  logic               slice_wr_en;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_row_end_r;
  logic               out_slice_end_r;
  logic               out_volume_end_r;

  // Move the whole pipeline whenever the output register is free
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && head_valid;

  assign row_wr_en   = adv && s1_valid_r && (s1_ctl_r.y_op != OP_NONE);
  assign slice_rd_en = adv && s1_valid_r && (s1_ctl_r.z_op != OP_NONE);
  assign slice_wr_en = adv && s2_valid_r && (s2_ctl_r.z_op != OP_NONE);

  sgd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_X)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (s1_row_addr_r),
    .wr_data (s1_value_r),
    .rd_en   (pop),
    .rd_addr (head_row_addr),
    .rd_data (row_rd_data)
  );

  sgd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_X * MAX_Y)
  ) u_slice_store (
    .clk     (clk),
    .wr_en   (slice_wr_en),
    .wr_addr (s2_slice_addr_r),
    .wr_data (s2_value_r),
    .rd_en   (slice_rd_en),
    .rd_addr (s1_slice_addr_r),
    .rd_data (slice_rd_data)
  );

  // y pass: take the row word, bypassing a write made in the same edge as the read
  assign row_old = s1_fwd_r ? s1_fwd_data_r : signed'(row_rd_data);
  assign y_value = (s1_ctl_r.y_op == OP_AVG) ?
                   avg2(row_old, s1_value_r, cfg.missing_en, cfg.missing_code) :
                   s1_value_r;

  // z pass: same bypass one stage later
  assign slice_old = s2_fwd_r ? s2_fwd_data_r : signed'(slice_rd_data);
  assign z_value   = (s2_ctl_r.z_op == OP_AVG) ?
                     avg2(slice_old, s2_value_r, cfg.missing_en, cfg.missing_code) :
                     s2_value_r;

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r && (s1_ctl_r.y_op != OP_FILL);
      out_valid_r <= s2_valid_r && (s2_ctl_r.z_op != OP_FILL);
    end
  end

  // Stage payloads and bypass captures
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r         <= head_ctl;
      s1_value_r       <= head_value;
      s1_row_addr_r    <= head_row_addr;
      s1_slice_addr_r  <= head_slice_addr;
      s1_fwd_r         <= row_wr_en && (s1_row_addr_r == head_row_addr);
      s1_fwd_data_r    <= s1_value_r;
      s2_ctl_r         <= s1_ctl_r;
      s2_value_r       <= y_value;
      s2_slice_addr_r  <= s1_slice_addr_r;
      s2_fwd_r         <= slice_wr_en && (s2_slice_addr_r == s1_slice_addr_r);
      s2_fwd_data_r    <= s2_value_r;
      out_value_r      <= z_value;
      out_row_end_r    <= s2_ctl_r.row_end;
      out_slice_end_r  <= s2_ctl_r.slice_end;
      out_volume_end_r <= s2_ctl_r.volume_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_row_end    = out_row_end_r;
  assign out_slice_end  = out_slice_end_r;
  assign out_volume_end = out_volume_end_r;

`include "staggered_grid_destagger_macros.svh"

  // Fill-only transactions never reach the output register
  `SGD_ASSERT_NEXT(a_fill_no_result, clk, rst_n, adv && !(s2_valid_r && (s2_ctl_r.z_op != OP_FILL)), !out_valid_r)
  // A held result keeps the pipeline frozen
  `SGD_ASSERT_NOW(a_stall_freezes, clk, rst_n, out_valid_r && out_stall, !pop && !row_wr_en && !slice_wr_en)

endmodule
